>>> rtl/pts_pkg.sv
// Shared types, constants and constant tables for the priority tone sequencer.
// Holds the effect table, the cascade scale and the microcode program.
// Depends on nothing; every other file imports it.
`default_nettype none

package pts_pkg;

	localparam int QUEUE_DEPTH = 12;
	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] EFFECT_COUNT   = 4'd14;
	localparam logic [3:0] CASCADE_EFFECT = 4'd3;

	localparam logic [1:0] KIND_PLAY = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	typedef struct packed {
		logic [11:0] freq;
		logic [8:0]  len;
		logic [4:0]  gap;
	} note_t;

	// Microcode: one control word per step of the sequencer
	typedef enum logic [3:0] {
		ST_FETCH,
		ST_KIND,
		ST_TKIND,
		ST_SKIND,
		ST_STOP,
		ST_PLAY,
		ST_PUSH,
		ST_TICK,
		ST_POP,
		ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_FLUSH,
		OP_PLAY_HEAD,
		OP_PUSH,
		OP_TICK_CHECK,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_IS_PLAY,
		C_IS_TICK,
		C_IS_STOP,
		C_PLAY_ABORT,
		C_LAST_NOTE,
		C_TICK_SKIP,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump_t;
		step_t jump_f;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(input step_t s);
		ctrl_word_t w;
		case (s)
			ST_FETCH: w = '{OP_ACCEPT,     C_IN_VALID,   ST_KIND,  ST_FETCH};
			ST_KIND:  w = '{OP_NOP,        C_IS_PLAY,    ST_PLAY,  ST_TKIND};
			ST_TKIND: w = '{OP_NOP,        C_IS_TICK,    ST_TICK,  ST_SKIND};
			ST_SKIND: w = '{OP_NOP,        C_IS_STOP,    ST_STOP,  ST_FETCH};
			ST_STOP:  w = '{OP_FLUSH,      C_ALWAYS,     ST_FETCH, ST_FETCH};
			ST_PLAY:  w = '{OP_PLAY_HEAD,  C_PLAY_ABORT, ST_FETCH, ST_PUSH};
			ST_PUSH:  w = '{OP_PUSH,       C_LAST_NOTE,  ST_FETCH, ST_PUSH};
			ST_TICK:  w = '{OP_TICK_CHECK, C_TICK_SKIP,  ST_FETCH, ST_POP};
			ST_POP:   w = '{OP_NOP,        C_OUT_FREE,   ST_EMIT,  ST_POP};
			ST_EMIT:  w = '{OP_EMIT,       C_ALWAYS,     ST_FETCH, ST_FETCH};
			default:  w = '{OP_NOP,        C_ALWAYS,     ST_FETCH, ST_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [2:0] effect_prio(input logic [3:0] eff);
		logic [2:0] p;
		case (eff)
			4'd0, 4'd1:                p = 3'd1;
			4'd2, 4'd3, 4'd12:         p = 3'd2;
			4'd4, 4'd6, 4'd7, 4'd11:   p = 3'd3;
			4'd5, 4'd8:                p = 3'd4;
			4'd9, 4'd13:               p = 3'd5;
			4'd10:                     p = 3'd6;
			default:                   p = 3'd0;
		endcase
		return p;
	endfunction

	function automatic logic [2:0] effect_notes(input logic [3:0] eff);
		logic [2:0] n;
		case (eff)
			4'd0, 4'd1, 4'd3, 4'd12:   n = 3'd1;
			4'd2, 4'd4, 4'd6:          n = 3'd2;
			4'd7, 4'd11, 4'd13:        n = 3'd3;
			4'd5, 4'd8, 4'd9, 4'd10:   n = 3'd4;
			default:                   n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic note_t effect_note(input logic [3:0] eff, input logic [1:0] idx);
		note_t t;
		case ({eff, idx})
			{4'd0, 2'd0}:  t = '{12'd880,  9'd18,  5'd0};
			{4'd1, 2'd0}:  t = '{12'd660,  9'd16,  5'd0};
			{4'd2, 2'd0}:  t = '{12'd220,  9'd45,  5'd10};
			{4'd2, 2'd1}:  t = '{12'd165,  9'd60,  5'd0};
			{4'd3, 2'd0}:  t = '{12'd0,    9'd40,  5'd6};
			{4'd4, 2'd0}:  t = '{12'd784,  9'd40,  5'd4};
			{4'd4, 2'd1}:  t = '{12'd1047, 9'd55,  5'd0};
			{4'd5, 2'd0}:  t = '{12'd659,  9'd40,  5'd3};
			{4'd5, 2'd1}:  t = '{12'd880,  9'd40,  5'd3};
			{4'd5, 2'd2}:  t = '{12'd1175, 9'd40,  5'd3};
			{4'd5, 2'd3}:  t = '{12'd1568, 9'd70,  5'd0};
			{4'd6, 2'd0}:  t = '{12'd160,  9'd60,  5'd4};
			{4'd6, 2'd1}:  t = '{12'd110,  9'd90,  5'd0};
			{4'd7, 2'd0}:  t = '{12'd1568, 9'd35,  5'd2};
			{4'd7, 2'd1}:  t = '{12'd1175, 9'd35,  5'd2};
			{4'd7, 2'd2}:  t = '{12'd1760, 9'd60,  5'd0};
			{4'd8, 2'd0}:  t = '{12'd1319, 9'd45,  5'd3};
			{4'd8, 2'd1}:  t = '{12'd1568, 9'd45,  5'd3};
			{4'd8, 2'd2}:  t = '{12'd1760, 9'd45,  5'd3};
			{4'd8, 2'd3}:  t = '{12'd2093, 9'd90,  5'd0};
			{4'd9, 2'd0}:  t = '{12'd523,  9'd70,  5'd8};
			{4'd9, 2'd1}:  t = '{12'd659,  9'd70,  5'd8};
			{4'd9, 2'd2}:  t = '{12'd784,  9'd70,  5'd8};
			{4'd9, 2'd3}:  t = '{12'd1047, 9'd140, 5'd0};
			{4'd10, 2'd0}: t = '{12'd659,  9'd120, 5'd20};
			{4'd10, 2'd1}: t = '{12'd523,  9'd120, 5'd20};
			{4'd10, 2'd2}: t = '{12'd440,  9'd150, 5'd20};
			{4'd10, 2'd3}: t = '{12'd330,  9'd320, 5'd0};
			{4'd11, 2'd0}: t = '{12'd392,  9'd50,  5'd5};
			{4'd11, 2'd1}: t = '{12'd523,  9'd50,  5'd5};
			{4'd11, 2'd2}: t = '{12'd659,  9'd50,  5'd0};
			{4'd12, 2'd0}: t = '{12'd1200, 9'd22,  5'd0};
			{4'd13, 2'd0}: t = '{12'd784,  9'd60,  5'd6};
			{4'd13, 2'd1}: t = '{12'd1047, 9'd60,  5'd6};
			{4'd13, 2'd2}: t = '{12'd1319, 9'd110, 5'd0};
			default:       t = '{12'd0,    9'd0,   5'd0};
		endcase
		return t;
	endfunction

	// Pentatonic steps for the cascade effect
	function automatic logic [11:0] penta_freq(input logic [3:0] s);
		logic [11:0] f;
		case (s)
			4'd0:    f = 12'd523;
			4'd1:    f = 12'd587;
			4'd2:    f = 12'd659;
			4'd3:    f = 12'd784;
			4'd4:    f = 12'd880;
			4'd5:    f = 12'd1047;
			4'd6:    f = 12'd1175;
			4'd7:    f = 12'd1319;
			4'd8:    f = 12'd1568;
			default: f = 12'd1760;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

>>> rtl/pts_note_ring.sv
// Note storage for the tone queue: one write port, one registered read port.
// Depends on pts_pkg for note_t and the queue depth.
`default_nettype none

module pts_note_ring
	import pts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_addr,
	input  wire note_t             wr_data,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output note_t                  rd_data
);

	note_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/priority_tone_sequencer.sv
// Priority tone sequencer: effect-driven note queue run by a microcoded sequencer.
// A play item runs fetch, kind, play, then (unless refused) a push step per note; a
// stop item fetch, kind, tkind, skind, stop; an unused kind ends at skind. A tick
// item ends at tick if no note is due, else waits at pop for the output register
// and emits; its beep is valid the cycle after emit. One item at a time: the step
// counter walks the program once per item. Reset: queue empty, priority 0, sound on,
// no note started; ring contents undefined. Depends on pts_pkg and pts_note_ring.
`default_nettype none

module priority_tone_sequencer
	import pts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // effect[3:0], cascade_level[11:4], now_ms[43:12]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // tone_freq_hz[11:0], tone_ms[20:12]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data  // sound_on
);

	step_t      step_q, step_next;
	ctrl_word_t ctrl;
	logic       cond_hit;

	logic [1:0]  kind_q;
	logic [3:0]  eff_q;
	logic [7:0]  lvl_q;
	logic [31:0] now_q;

	logic [SLOT_W-1:0]  read_q;
	logic [COUNT_W-1:0] held_q;
	logic [2:0]         prio_q;
	logic [31:0]        next_start_q;
	logic               started_q;
	logic               sound_on_q;
	logic [1:0]         idx_q;

	logic        out_valid_q;
	logic [11:0] out_freq_q;
	logic [8:0]  out_ms_q;

	logic [2:0]  eff_prio;
	logic [2:0]  eff_n;
	logic        play_ok, preempt, play_abort, last_note, tick_skip, out_free;
	logic [31:0] since_start;
	logic [3:0]  casc_step;
	note_t       rom_note, push_note, rd_note;
	logic [COUNT_W:0]   slot_sum;
	logic [SLOT_W-1:0]  wr_slot;
	logic               wr_en;

	// Datapath conditions
	assign eff_prio    = effect_prio(eff_q);
	assign eff_n       = effect_notes(eff_q);
	assign play_ok     = sound_on_q && (eff_q < EFFECT_COUNT);
	assign preempt     = (eff_prio > prio_q) || (held_q == '0);
	assign play_abort  = !play_ok || (!preempt && (eff_prio < prio_q));
	assign last_note   = ({1'b0, idx_q} + 3'd1) == eff_n;
	assign since_start = now_q - next_start_q;
	assign tick_skip   = !sound_on_q || (held_q == '0) || (started_q && since_start[31]);
	assign out_free    = !out_valid_q || m_tready;

	// Clamp level-1 to the ten pentatonic steps
	always_comb begin
		if (lvl_q == 8'd0) begin
			casc_step = 4'd0;
		end else if (lvl_q > 8'd10) begin
			casc_step = 4'd9;
		end else begin
			casc_step = 4'(lvl_q - 8'd1);
		end
	end

	always_comb begin
		rom_note  = effect_note(eff_q, idx_q);
		push_note = rom_note;
		if (eff_q == CASCADE_EFFECT) begin
			push_note.freq = penta_freq(casc_step);
		end
	end

	always_comb begin
		slot_sum = (COUNT_W + 1)'(read_q) + (COUNT_W + 1)'(held_q);
		if (slot_sum >= (COUNT_W + 1)'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - (COUNT_W + 1)'(QUEUE_DEPTH);
		end
		wr_slot = slot_sum[SLOT_W-1:0];
	end

	assign wr_en = (ctrl.op == OP_PUSH) && (held_q < COUNT_W'(QUEUE_DEPTH));

	pts_note_ring u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_slot),
		.wr_data (push_note),
		.rd_addr (read_q),
		.rd_data (rd_note)
	);

	// Sequencer: fetch control word, evaluate its condition, pick the next step
	assign ctrl = ucode_rom(step_q);

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:     cond_hit = 1'b1;
			C_IN_VALID:   cond_hit = s_tvalid;
			C_IS_PLAY:    cond_hit = (kind_q == KIND_PLAY);
			C_IS_TICK:    cond_hit = (kind_q == KIND_TICK);
			C_IS_STOP:    cond_hit = (kind_q == KIND_STOP);
			C_PLAY_ABORT: cond_hit = play_abort;
			C_LAST_NOTE:  cond_hit = last_note;
			C_TICK_SKIP:  cond_hit = tick_skip;
			C_OUT_FREE:   cond_hit = out_free;
			default:      cond_hit = 1'b1;
		endcase
		step_next = cond_hit ? ctrl.jump_t : ctrl.jump_f;
	end

	always_comb begin
		s_tready  = (ctrl.op == OP_ACCEPT);
		// take a register write only between items, never beside an incoming item
		cfg_ready = (ctrl.op == OP_ACCEPT) && !s_tvalid;
		m_tvalid  = out_valid_q;
		m_tdata   = {3'b000, out_ms_q, out_freq_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_next;
		end
	end

	// Item latch: payload only
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			eff_q  <= s_tdata[3:0];
			lvl_q  <= s_tdata[11:4];
			now_q  <= s_tdata[43:12];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT) begin
			out_freq_q <= rd_note.freq;
			out_ms_q   <= rd_note.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q       <= '0;
			held_q       <= '0;
			prio_q       <= '0;
			next_start_q <= '0;
			started_q    <= 1'b0;
			sound_on_q   <= 1'b1;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				OP_FLUSH: begin
					read_q <= '0;
					held_q <= '0;
					prio_q <= '0;
				end
				OP_PLAY_HEAD: begin
					idx_q <= '0;
					if (play_ok && preempt) begin
						read_q <= '0;
						held_q <= '0;
						prio_q <= eff_prio;
					end
				end
				OP_PUSH: begin
					idx_q <= idx_q + 2'd1;
					if (wr_en) begin
						held_q <= held_q + COUNT_W'(1);
					end
				end
				OP_TICK_CHECK: begin
					if (held_q == '0) begin
						prio_q <= '0;
					end
				end
				OP_EMIT: begin
					out_valid_q  <= 1'b1;
					started_q    <= 1'b1;
					next_start_q <= now_q + 32'(rd_note.len) + 32'(rd_note.gap);
					held_q       <= held_q - COUNT_W'(1);
					if (read_q == SLOT_W'(QUEUE_DEPTH - 1)) begin
						read_q <= '0;
					end else begin
						read_q <= read_q + SLOT_W'(1);
					end
					// drained: release the priority
					if (held_q == COUNT_W'(1)) begin
						prio_q <= '0;
					end
				end
				default: begin
				end
			endcase
			// Sound off empties the queue; only written while idle
			if (cfg_valid && cfg_ready) begin
				sound_on_q <= cfg_data;
				if (!cfg_data) begin
					read_q <= '0;
					held_q <= '0;
					prio_q <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for priority_tone_sequencer: directed table, then random phases.
// Beeps are predicted by an in-bench model of the effect queue and checked in order.
// Depends on pts_pkg and the RTL of the sequencer.
`timescale 1ns / 100ps

module testbench;
	import pts_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int DIR_ROWS      = 25;
	localparam int PHASES        = 8;
	localparam int SETTLE_CYCLES = 24;
	localparam int WATCH_LIMIT   = 2000;

	// Effect table: priority, note count, then four notes per effect
	localparam int RANK [14]  = '{1, 1, 2, 2, 3, 4, 3, 3, 4, 5, 6, 3, 2, 5};
	localparam int TONES [14] = '{1, 1, 2, 1, 2, 4, 2, 3, 4, 4, 4, 3, 1, 3};
	localparam int HZ_TAB [56] = '{
		880, 0, 0, 0,        660, 0, 0, 0,        220, 165, 0, 0,      0, 0, 0, 0,
		784, 1047, 0, 0,     659, 880, 1175, 1568, 160, 110, 0, 0,     1568, 1175, 1760, 0,
		1319, 1568, 1760, 2093, 523, 659, 784, 1047, 659, 523, 440, 330,
		392, 523, 659, 0,    1200, 0, 0, 0,       784, 1047, 1319, 0};
	localparam int LEN_TAB [56] = '{
		18, 0, 0, 0,         16, 0, 0, 0,         45, 60, 0, 0,        40, 0, 0, 0,
		40, 55, 0, 0,        40, 40, 40, 70,      60, 90, 0, 0,        35, 35, 60, 0,
		45, 45, 45, 90,      70, 70, 70, 140,     120, 120, 150, 320,
		50, 50, 50, 0,       22, 0, 0, 0,         60, 60, 110, 0};
	localparam int GAP_TAB [56] = '{
		0, 0, 0, 0,          0, 0, 0, 0,          10, 0, 0, 0,         6, 0, 0, 0,
		4, 0, 0, 0,          3, 3, 3, 0,          4, 0, 0, 0,          2, 2, 0, 0,
		3, 3, 3, 0,          8, 8, 8, 0,          20, 20, 20, 0,
		5, 5, 0, 0,          0, 0, 0, 0,          6, 6, 0, 0};
	localparam int SCALE_HZ [10] = '{523, 587, 659, 784, 880, 1047, 1175, 1319, 1568, 1760};

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  effect;
		logic [7:0]  level;
		logic [31:0] now;
	} stim_t;

	typedef struct packed {
		logic [11:0] hz;
		logic [8:0]  ms;
	} beep_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_BEEP} chk_t;

	typedef struct packed {
		stim_t       stim;
		chk_t        chk;
		logic [11:0] hz;
		logic [8:0]  ms;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;  // effect[3:0], cascade_level[11:4], now_ms[43:12]
	logic [1:0]  s_tuser   = '0;  // kind[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;         // tone_freq_hz[11:0], tone_ms[20:12]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;

	priority_tone_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted queue state
	logic [11:0] ring_hz  [QUEUE_DEPTH];
	logic [8:0]  ring_len [QUEUE_DEPTH];
	logic [4:0]  ring_gap [QUEUE_DEPTH];
	int unsigned rd_ptr   = 0;
	int unsigned fill     = 0;
	int unsigned prio_now = 0;
	logic [31:0] due_ms   = '0;
	bit          started  = 1'b0;
	bit          snd_en   = 1'b1;

	beep_t       pending_beeps [$];
	int          items_sent  = 0;
	int          beeps_seen  = 0;
	int          miss_cnt    = 0;
	int          quiet_cycles = 0;
	int          tx_pct      = 0;
	int          rx_pct      = 0;
	int          rx_hold     = 0;
	logic [31:0] cur_ms      = '0;

	task automatic push_note(input int unsigned hz, input int unsigned len, input int unsigned gap);
		int unsigned slot;
		if (fill >= QUEUE_DEPTH)
			return;
		slot = (rd_ptr + fill) % QUEUE_DEPTH;
		ring_hz[slot]  = hz[11:0];
		ring_len[slot] = len[8:0];
		ring_gap[slot] = gap[4:0];
		fill++;
	endtask

	task automatic predict_beep(input stim_t it, output bit fired, output beep_t b);
		int unsigned p;
		int unsigned step;
		int unsigned slot;
		logic [31:0] lag;
		fired = 1'b0;
		b = '0;
		case (it.kind)
			KIND_PLAY: begin
				if (!snd_en || it.effect >= EFFECT_COUNT)
					return;
				p = RANK[it.effect];
				if (p > prio_now || fill == 0) begin
					fill = 0;
					rd_ptr = 0;
					prio_now = p;
				end else if (p < prio_now) begin
					return;
				end
				if (it.effect == CASCADE_EFFECT) begin
					step = (it.level == 0) ? 0 : it.level - 1;
					if (step > 9)
						step = 9;
					push_note(SCALE_HZ[step], LEN_TAB[it.effect * 4], GAP_TAB[it.effect * 4]);
				end else begin
					for (int i = 0; i < TONES[it.effect]; i++)
						push_note(HZ_TAB[it.effect * 4 + i], LEN_TAB[it.effect * 4 + i],
							GAP_TAB[it.effect * 4 + i]);
				end
			end
			KIND_TICK: begin
				lag = it.now - due_ms;
				if (!snd_en || fill == 0) begin
					if (fill == 0)
						prio_now = 0;
				end else if (!(started && lag[31])) begin
					slot = rd_ptr;
					rd_ptr = (slot + 1) % QUEUE_DEPTH;
					fill--;
					b.hz = ring_hz[slot];
					b.ms = ring_len[slot];
					started = 1'b1;
					due_ms = it.now + ring_len[slot] + ring_gap[slot];
					if (fill == 0)
						prio_now = 0;
					fired = 1'b1;
				end
			end
			KIND_STOP: begin
				fill = 0;
				rd_ptr = 0;
				prio_now = 0;
			end
			default: ;
		endcase
	endtask

	function automatic dir_row_t row_of(input logic [1:0] k, input logic [3:0] e,
		input logic [7:0] l, input logic [31:0] n, input chk_t c,
		input logic [11:0] hz, input logic [8:0] ms);
		dir_row_t d;
		d.stim = '{k, e, l, n};
		d.chk = c;
		d.hz = hz;
		d.ms = ms;
		return d;
	endfunction

	function automatic dir_row_t dir_entry(input int r);
		dir_row_t d;
		case (r)
			0:  d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd0,   CHK_SILENT, 12'd0,    9'd0);
			1:  d = row_of(KIND_PLAY,  4'd0,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			2:  d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd0,   CHK_BEEP,   12'd880,  9'd18);
			3:  d = row_of(KIND_PLAY,  4'd10, 8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			4:  d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd5,   CHK_SILENT, 12'd0,    9'd0);
			5:  d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd18,  CHK_BEEP,   12'd659,  9'd120);
			6:  d = row_of(KIND_PLAY,  4'd0,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			7:  d = row_of(KIND_PLAY,  4'd14, 8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			8:  d = row_of(KIND_SPARE, 4'd15, 8'd255, '1,      CHK_SILENT, 12'd0,    9'd0);
			9:  d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd158, CHK_BEEP,   12'd523,  9'd120);
			10: d = row_of(KIND_STOP,  4'd0,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			11: d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd400, CHK_SILENT, 12'd0,    9'd0);
			12: d = row_of(KIND_PLAY,  4'd3,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			13: d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd400, CHK_BEEP,   12'd523,  9'd40);
			14: d = row_of(KIND_PLAY,  4'd3,  8'd255, 32'd0,   CHK_MODEL,  12'd0,    9'd0);
			15: d = row_of(KIND_TICK,  4'd0,  8'd0,   32'd446, CHK_BEEP,   12'd1760, 9'd40);
			16: d = row_of(KIND_PLAY,  4'd3,  8'd10,  32'd0,   CHK_MODEL,  12'd0,    9'd0);
			17: d = row_of(KIND_PLAY,  4'd3,  8'd5,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			18: d = row_of(KIND_PLAY,  4'd12, 8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			19: d = row_of(KIND_PLAY,  4'd9,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			20: d = row_of(KIND_PLAY,  4'd9,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			21: d = row_of(KIND_PLAY,  4'd13, 8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			// ring is full after this one: three notes fall off
			22: d = row_of(KIND_PLAY,  4'd9,  8'd0,   32'd0,   CHK_MODEL,  12'd0,    9'd0);
			// wrapped time reads as before the due time
			23: d = row_of(KIND_TICK,  4'd0,  8'd0,   '1,      CHK_SILENT, 12'd0,    9'd0);
			default: d = row_of(KIND_TICK, 4'd0, 8'd0, 32'h7FFF_FFFF, CHK_BEEP, 12'd523, 9'd70);
		endcase
		return d;
	endfunction

	task automatic send_item(input stim_t it, input chk_t chk, input logic [11:0] hz,
		input logic [8:0] ms);
		bit    fired;
		beep_t b;
		int    gap;
		gap = (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {4'b0, it.now, it.level, it.effect};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		predict_beep(it, fired, b);
		case (chk)
			CHK_MODEL: if (fired) pending_beeps.push_back(b);
			CHK_BEEP: begin
				b.hz = hz;
				b.ms = ms;
				pending_beeps.push_back(b);
			end
			default: ;
		endcase
	endtask

	task automatic random_item(output stim_t it);
		int roll;
		int hop;
		roll = $urandom_range(0, 99);
		it.kind   = KIND_TICK;
		it.effect = 4'($urandom);
		it.level  = 8'($urandom);
		it.now    = $urandom;
		if (roll < 30) begin
			it.kind = KIND_PLAY;
			it.effect = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(14, 15))
				: 4'($urandom_range(0, 13));
			if ($urandom_range(0, 99) < 70)
				it.level = 8'($urandom_range(0, 12));
		end else if (roll < 85) begin
			hop = $urandom_range(0, 99);
			// keep forward jumps under half the wrap so queued notes stay reachable
			if (hop < 4)
				cur_ms = cur_ms + $urandom_range(1, 32'h4000_0000);
			else if (hop < 8)
				cur_ms = cur_ms - $urandom_range(1, 60);
			else
				cur_ms = cur_ms + $urandom_range(0, 150);
			it.now = cur_ms;
		end else if (roll < 90) begin
			it.kind = KIND_STOP;
		end else if (roll < 93) begin
			it.kind = KIND_SPARE;
		end else begin
			it.kind = 2'($urandom_range(0, 3));
			if (it.kind == KIND_TICK)
				cur_ms = it.now;
		end
	endtask

	// Drop valid, wait for every beep, then let the block finish its current item
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_beeps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sound(input bit on);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= on;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		snd_en = on;
		if (!on) begin
			fill = 0;
			rd_ptr = 0;
			prio_now = 0;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic flag_miss(input string what, input beep_t want, input logic [23:0] got);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("%0t: %s: expected %0d Hz %0d ms, got %0d Hz %0d ms", $realtime, what,
				want.hz, want.ms, got[11:0], got[20:12]);
	endtask

	// Receiver back-pressure in bursts
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
			rx_hold <= $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : beep_check
		beep_t want;
		if (m_tvalid && m_tready) begin
			beeps_seen++;
			if (pending_beeps.size() == 0) begin
				flag_miss("unexpected beep", '0, m_tdata);
			end else begin
				want = pending_beeps.pop_front();
				if (m_tdata[11:0] !== want.hz || m_tdata[20:12] !== want.ms)
					flag_miss("beep mismatch", want, m_tdata);
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d beeps outstanding",
				quiet_cycles, pending_beeps.size());
			$display("priority_tone_sequencer test failed");
			$finish;
		end
	end

	initial begin : main
		dir_row_t d;
		stim_t    it;
		bit       on;
		int       count;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tx_pct = 20;
		rx_pct = 20;

		for (int r = 0; r < DIR_ROWS; r++) begin
			d = dir_entry(r);
			send_item(d.stim, d.chk, d.hz, d.ms);
		end
		cur_ms = 32'h7FFF_FFFF;

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			on = !(ph == 1 || ph == 4);
			write_sound(on);
			count = on ? 250 : 60;
			// last phase runs flat out on both sides
			tx_pct = (ph == PHASES - 1) ? 0 : ((ph % 3 == 0) ? 30 : 10);
			rx_pct = tx_pct;
			for (int i = 0; i < count; i++) begin
				random_item(it);
				send_item(it, CHK_MODEL, '0, '0);
			end
		end
		settle();

		$display("Ran %0d items over %0d sound settings; %0d beeps checked, %0d mismatches.",
			items_sent, PHASES, beeps_seen, miss_cnt);
		if (miss_cnt == 0 && pending_beeps.size() == 0)
			$display("priority_tone_sequencer test passed");
		else
			$display("priority_tone_sequencer test failed");
		$finish;
	end

endmodule
